>>> src/wtr_pkg.sv
// Shared types, constants and the sequencer's control store for the winner tree.
// Depends on nothing; the interfaces, the top level and the testbench import it.
package wtr_pkg;

    // Field widths of the request and response payloads
    localparam int IDX_W      = 4;
    localparam int VAL_W      = 32;
    localparam int LEAVES_DEF = 16;

    // Reset value of every leaf
    localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

    // Microprogram address
    typedef logic [2:0] t_upc;

    localparam t_upc UPC_CLR  = 3'd0;  // clearing pass after reset
    localparam t_upc UPC_IDLE = 3'd1;  // wait for a request
    localparam t_upc UPC_SIB  = 3'd2;  // read sibling's winner
    localparam t_upc UPC_VAL  = 3'd3;  // read sibling winner's leaf value
    localparam t_upc UPC_CMP  = 3'd4;  // play the match, step up one level
    localparam t_upc UPC_PUT  = 3'd5;  // hand result to output register

    // Branch conditions
    typedef enum logic [2:0] {
        COND_ALWAYS   = 3'd0,
        COND_IN       = 3'd1,
        COND_ROOT     = 3'd2,
        COND_OUT_FREE = 3'd3,
        COND_CLR_DONE = 3'd4
    } t_cond;

    // One control word
    typedef struct packed {
        logic  take;     // request port ready
        logic  rd_node;  // read node winner store
        logic  rd_leaf;  // read leaf value store
        logic  cmp;      // match and node write
        logic  put;      // load output register
        logic  clr;      // write reset contents
        t_cond cond;
        t_upc  tgt_t;    // next step when cond holds
        t_upc  tgt_f;    // next step otherwise
    } t_uword;

    // Control store
    function automatic t_uword urom(input t_upc upc);
        t_uword w;
        w = '0;
        unique case (upc)
            UPC_CLR: begin
                w.clr = 1'b1;  w.cond = COND_CLR_DONE;
                w.tgt_t = UPC_IDLE;  w.tgt_f = UPC_CLR;
            end
            UPC_IDLE: begin
                w.take = 1'b1;  w.cond = COND_IN;
                w.tgt_t = UPC_SIB;  w.tgt_f = UPC_IDLE;
            end
            UPC_SIB: begin
                w.rd_node = 1'b1;  w.cond = COND_ALWAYS;
                w.tgt_t = UPC_VAL;  w.tgt_f = UPC_VAL;
            end
            UPC_VAL: begin
                w.rd_leaf = 1'b1;  w.cond = COND_ALWAYS;
                w.tgt_t = UPC_CMP;  w.tgt_f = UPC_CMP;
            end
            UPC_CMP: begin
                w.cmp = 1'b1;  w.cond = COND_ROOT;
                w.tgt_t = UPC_PUT;  w.tgt_f = UPC_SIB;
            end
            UPC_PUT: begin
                w.put = 1'b1;  w.cond = COND_OUT_FREE;
                w.tgt_t = UPC_IDLE;  w.tgt_f = UPC_PUT;
            end
            default: begin
                w.cond = COND_ALWAYS;
                w.tgt_t = UPC_CLR;  w.tgt_f = UPC_CLR;
            end
        endcase
        return w;
    endfunction

endpackage

>>> src/wtr_if.sv
// Request and response channel interfaces of the winner tree.
// Depends on wtr_pkg for the field widths.
interface wtr_req_if import wtr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        leaf_index;
    logic signed [VAL_W-1:0] new_value;

    modport source (output valid, output leaf_index, output new_value, input ready);
    modport sink   (input valid, input leaf_index, input new_value, output ready);
endinterface

interface wtr_rsp_if import wtr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        winner_index;
    logic signed [VAL_W-1:0] winner_value;

    modport source (output valid, output winner_index, output winner_value, input ready);
    modport sink   (input valid, input winner_index, input winner_value, output ready);
endinterface

>>> src/wtr_ram.sv
// Simple dual-port RAM: one write and one registered read per cycle.
// Depends on nothing; holds the leaf values and the node winners.
module wtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/winner_tree_replace.sv
// Winner tree top level: microcoded replay of one leaf-to-root path per request.
// Depends on wtr_pkg, wtr_req_if / wtr_rsp_if and wtr_ram.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  i_req    | in  | valid / ready | leaf_index[3:0], new_value[31:0] signed
//  o_rsp    | out | valid / ready | winner_index[3:0], winner_value[31:0] signed
//
//  Each tree level of a request's path costs a node-store read, a leaf-store read and
//  a compare/write, since both stores are single-read RAMs. One request is in flight
//  at a time.
//  After reset a clearing pass loads the stores; i_req.ready is low.
//  A result waits in the output register; the next request is taken meanwhile and
//  its result holds in the last step until the register frees up.
module winner_tree_replace
    import wtr_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wtr_req_if.sink    i_req,
    wtr_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(LEAVES);   // leaf index width
    localparam int PW = IW + 1;           // heap position width

    // leftmost leaf of the subtree under internal node n
    function automatic logic [IW-1:0] leftmost(input logic [IW-1:0] n);
        int            m;
        logic [PW-1:0] sh;
        m = 0;
        for (int b = 0; b < IW; b++) begin
            if (n[b]) m = b;
        end
        sh = {1'b0, n} << (IW - m);
        return sh[IW-1:0];
    endfunction

    // sequencer
    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   cond_ok;

    // datapath registers
    logic [PW-1:0]           r_pos;
    logic [IW-1:0]           r_cur_idx;
    logic signed [VAL_W-1:0] r_cur_val;
    logic [IW-1:0]           r_sw_idx;
    logic [IW-1:0]           r_clr;
    logic                    r_rsp_valid;
    logic [IDX_W-1:0]        r_rsp_idx;
    logic signed [VAL_W-1:0] r_rsp_val;

    logic                    accept;
    logic                    out_free;
    logic [PW-1:0]           sib_pos;
    logic [IW-1:0]           parent;
    logic [IW-1:0]           sw_idx;
    logic [IW-1:0]           node_rdata;
    logic [VAL_W-1:0]        leaf_rdata;
    logic signed [VAL_W-1:0] sib_val;
    logic                    cur_wins;

    // RAM ports
    logic                    leaf_we;
    logic [IW-1:0]           leaf_waddr;
    logic [VAL_W-1:0]        leaf_wdata;
    logic                    node_we;
    logic [IW-1:0]           node_waddr;
    logic [IW-1:0]           node_wdata;

    assign uw       = urom(r_upc);
    assign accept   = uw.take && i_req.valid;
    assign out_free = !r_rsp_valid || o_rsp.ready;
    assign sib_pos  = r_pos ^ PW'(1);
    assign parent   = r_pos[PW-1:1];
    // at leaf level the sibling is itself a leaf
    assign sw_idx   = r_pos[IW] ? sib_pos[IW-1:0] : node_rdata;
    assign sib_val  = $signed(leaf_rdata);
    // left child wins ties
    assign cur_wins = r_pos[0] ? (r_cur_val < sib_val) : (r_cur_val <= sib_val);

    // branch condition decode
    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS:   cond_ok = 1'b1;
            COND_IN:       cond_ok = i_req.valid;
            COND_ROOT:     cond_ok = (parent == IW'(1));
            COND_OUT_FREE: cond_ok = out_free;
            COND_CLR_DONE: cond_ok = (r_clr == IW'(LEAVES - 1));
            default:       cond_ok = 1'b1;
        endcase
        n_upc = cond_ok ? uw.tgt_t : uw.tgt_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_CLR;
            r_clr <= '0;
        end else begin
            r_upc <= n_upc;
            if (uw.clr) r_clr <= r_clr + IW'(1);
        end
    end

    // store write ports: reset contents, new leaf, match winner
    always_comb begin
        leaf_we    = uw.clr || accept;
        leaf_waddr = uw.clr ? r_clr : IW'(i_req.leaf_index);
        leaf_wdata = uw.clr ? INT_MAX : i_req.new_value;
        node_we    = uw.clr || uw.cmp;
        node_waddr = uw.clr ? r_clr : parent;
        node_wdata = uw.clr ? leftmost(r_clr) : (cur_wins ? r_cur_idx : r_sw_idx);
    end

    wtr_ram #(.WIDTH(VAL_W), .DEPTH(LEAVES)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_re    (uw.rd_leaf),
        .i_raddr (sw_idx),
        .o_rdata (leaf_rdata)
    );

    wtr_ram #(.WIDTH(IW), .DEPTH(LEAVES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (uw.rd_node),
        .i_raddr (sib_pos[IW-1:0]),
        .o_rdata (node_rdata)
    );

    // path registers: current position and its winner
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos     <= {1'b1, IW'(i_req.leaf_index)};
            r_cur_idx <= IW'(i_req.leaf_index);
            r_cur_val <= i_req.new_value;
        end else if (uw.cmp) begin
            r_pos <= {1'b0, parent};
            if (!cur_wins) begin
                r_cur_idx <= r_sw_idx;
                r_cur_val <= sib_val;
            end
        end
        if (uw.rd_leaf) r_sw_idx <= sw_idx;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (uw.put && out_free) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.put && out_free) begin
            r_rsp_idx <= IDX_W'(r_cur_idx);
            r_rsp_val <= r_cur_val;
        end
    end

    assign i_req.ready        = uw.take;
    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.winner_index = r_rsp_idx;
    assign o_rsp.winner_value = r_rsp_val;

`ifndef NO_ASSERTIONS
    // a taken request starts the replay at leaf level
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_upc == UPC_SIB) && r_pos[IW])
        else $error("replay did not start at leaf level");

    // matches are only played below the root
    a_cmp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_CMP) |-> (r_pos > PW'(1)))
        else $error("match played at or above root");

    // no request during the clearing pass
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_CLR) |-> !i_req.ready)
        else $error("request taken while clearing");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !o_rsp.ready) |=> $stable(r_rsp_val) && $stable(r_rsp_idx))
        else $error("pending result overwritten");
`endif

endmodule

>>> verif/winner_tree_replace_tb.sv
// Self-checking testbench for winner_tree_replace: directed table, then random leaf updates.
// Depends on wtr_pkg, wtr_req_if / wtr_rsp_if and the winner_tree_replace RTL in src.
`timescale 1ns / 100ps

module winner_tree_replace_tb;
    import wtr_pkg::*;

    localparam int TREE_LEAVES  = LEAVES_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int TAIL_ITEMS   = 200;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 50;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [IDX_W-1:0]        winner_index;
        logic signed [VAL_W-1:0] winner_value;
    } t_tree_result;

    typedef struct packed {
        logic [IDX_W-1:0]        leaf_index;
        logic signed [VAL_W-1:0] new_value;
        logic                    typed;
        t_tree_result            typed_result;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    wtr_req_if req_if ();
    wtr_rsp_if rsp_if ();

    winner_tree_replace #(
        .LEAVES (TREE_LEAVES)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Shadow copy of the tree
    logic signed [VAL_W-1:0] leaf_store [TREE_LEAVES];
    logic [IDX_W-1:0]        node_store [TREE_LEAVES];

    t_tree_result expected_winners [$];
    t_stim_row    directed_rows [$];
    t_tree_result oldest_winner;

    int  error_count;
    int  cycle_count;
    bit  long_hold_req;
    bit  quiet_tail;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Winner leaf of a heap position: leaves sit at TREE_LEAVES and up
    function automatic int heap_winner(input int pos);
        if (pos >= TREE_LEAVES)
            return pos - TREE_LEAVES;
        return int'(node_store[pos]);
    endfunction

    function automatic void reset_tree();
        int p;
        for (int n = 0; n < TREE_LEAVES; n++)
            leaf_store[n] = INT_MAX;
        node_store[0] = '0;
        for (int n = 1; n < TREE_LEAVES; n++) begin
            p = n;
            while (p < TREE_LEAVES)
                p = p << 1;
            node_store[n] = IDX_W'(p - TREE_LEAVES);
        end
    endfunction

    // Write one leaf, replay its path to the root, return the new overall winner
    function automatic t_tree_result replay_path(input logic [IDX_W-1:0] idx,
                                                 input logic signed [VAL_W-1:0] val);
        t_tree_result res;
        int pos;
        int parent;
        int lw;
        int rw;
        leaf_store[idx] = val;
        pos = TREE_LEAVES + int'(idx);
        while (pos > 1) begin
            parent = pos >> 1;
            lw = heap_winner(parent << 1);
            rw = heap_winner((parent << 1) | 1);
            // left wins ties
            node_store[parent] = (leaf_store[lw] <= leaf_store[rw]) ? IDX_W'(lw) : IDX_W'(rw);
            pos = parent;
        end
        res.winner_index = node_store[1];
        res.winner_value = leaf_store[node_store[1]];
        return res;
    endfunction

    // Mix of small values for ties, extremes, and full-range values
    function automatic logic signed [VAL_W-1:0] next_leaf_value();
        case ($urandom_range(0, 9)) inside
            [0:2]: return $signed(VAL_W'($urandom_range(0, 6))) - 32'sd3;
            3: begin
                case ($urandom_range(0, 3))
                    0: return INT_MAX;
                    1: return VAL_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // Offer one request, wait for it to be taken, then maybe idle a burst
    task automatic offer_request(input logic [IDX_W-1:0] idx,
                                 input logic signed [VAL_W-1:0] val,
                                 input logic typed,
                                 input t_tree_result typed_res,
                                 input bit allow_gap);
        t_tree_result predicted;
        req_if.valid      <= 1'b1;
        req_if.leaf_index <= idx;
        req_if.new_value  <= val;
        @(posedge i_clk);
        while (!(req_if.valid && req_if.ready))
            @(posedge i_clk);
        predicted = replay_path(idx, val);
        expected_winners.push_back(typed ? typed_res : predicted);
        if (allow_gap && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Response side: random stall bursts, one long hold-off, none in the tail
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (quiet_tail) begin
                rsp_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Compare each taken response with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_winners.size() == 0) begin
                report_mismatch($sformatf("response %0d/%0d with nothing outstanding",
                                          rsp_if.winner_index, rsp_if.winner_value));
            end else begin
                oldest_winner = expected_winners.pop_front();
                if (rsp_if.winner_index !== oldest_winner.winner_index)
                    report_mismatch($sformatf("winner_index %0d, want %0d",
                                              rsp_if.winner_index,
                                              oldest_winner.winner_index));
                if (rsp_if.winner_value !== oldest_winner.winner_value)
                    report_mismatch($sformatf("winner_value %0d, want %0d",
                                              rsp_if.winner_value,
                                              oldest_winner.winner_value));
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("winner_tree_replace verification failed");
        $finish;
    end

    // Main sequence
    initial begin
        t_stim_row    row;
        t_tree_result none;
        error_count   = 0;
        long_hold_req = 1'b0;
        quiet_tail    = 1'b0;
        none          = '0;
        reset_tree();

        i_rst_n           <= 1'b0;
        req_if.valid      <= 1'b0;
        req_if.leaf_index <= '0;
        req_if.new_value  <= '0;

        // Directed table: known answers where the tree state is obvious
        directed_rows.push_back(t_stim_row'{4'd0,  INT_MAX, 1'b1, '{4'd0,  INT_MAX}});
        directed_rows.push_back(t_stim_row'{4'd15, VAL_MIN, 1'b1, '{4'd15, VAL_MIN}});
        // tie at the extreme: leftmost leaf wins
        directed_rows.push_back(t_stim_row'{4'd0,  VAL_MIN, 1'b1, '{4'd0,  VAL_MIN}});
        directed_rows.push_back(t_stim_row'{4'd0,  32'sd0,  1'b1, '{4'd15, VAL_MIN}});
        directed_rows.push_back(t_stim_row'{4'd15, INT_MAX, 1'b1, '{4'd0,  32'sd0}});
        directed_rows.push_back(t_stim_row'{4'd7,  -32'sd1, 1'b1, '{4'd7,  -32'sd1}});
        // tie across the two halves of the tree
        directed_rows.push_back(t_stim_row'{4'd8,  -32'sd1, 1'b1, '{4'd7,  -32'sd1}});
        directed_rows.push_back(t_stim_row'{4'd7,  32'sd0,  1'b1, '{4'd8,  -32'sd1}});
        directed_rows.push_back(t_stim_row'{4'd8,  INT_MAX, 1'b1, '{4'd0,  32'sd0}});
        // bulk build: one write per leaf, checked by the predictor
        for (int i = 0; i < TREE_LEAVES; i++) begin
            row = '0;
            row.leaf_index = IDX_W'(i);
            row.new_value  = $signed(VAL_W'(i * 32'h1357_9BDF));
            directed_rows.push_back(row);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            offer_request(directed_rows[k].leaf_index, directed_rows[k].new_value,
                          directed_rows[k].typed, directed_rows[k].typed_result, 1'b1);

        // Random updates
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300)
                long_hold_req = 1'b1;
            if (n == 800) begin
                // let the tree drain completely before going on
                req_if.valid <= 1'b0;
                @(posedge i_clk);
                while (expected_winners.size() != 0)
                    @(posedge i_clk);
            end
            if (n == RANDOM_ITEMS - TAIL_ITEMS)
                quiet_tail = 1'b1;
            offer_request(IDX_W'($urandom_range(0, TREE_LEAVES - 1)), next_leaf_value(),
                          1'b0, none, !quiet_tail);
        end
        req_if.valid <= 1'b0;

        // Wait for the last responses, then watch for strays
        while (expected_winners.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("winner_tree_replace verification clean");
        else
            $display("winner_tree_replace verification failed");
        $finish;
    end

endmodule
